// ===== sv/grmc_pkg.sv =====
package grmc_pkg;

  // map geometry
  localparam int MAP_SIDE = 8;
  localparam int MAP_ROW_W = $clog2(MAP_SIDE);
  localparam int MAP_IDX_W = $clog2(MAP_SIDE * MAP_SIDE);

  // sine table: quarter wave plus the full-scale point
  localparam int TRIG_TABLE_DEPTH = 1024;
  localparam int TRIG_LOG2 = $clog2(TRIG_TABLE_DEPTH);
  localparam int TRIG_SHIFT = 16 - TRIG_LOG2;
  localparam int QTR_ENTRIES = TRIG_TABLE_DEPTH / 4 + 1;
  localparam int QTR_IDX_W = $clog2(QTR_ENTRIES);
  localparam logic [15:0] PHASE_MASK = 16'(32'hFFFF_FFFF << TRIG_SHIFT);
  localparam logic [14:0] QUARTER_TURN = 15'd16384;
  localparam logic [15:0] COS_OFFSET = 16'd16384;

  // polynomial coefficients, Q30
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint A1 = 64'sd1686629713;
  localparam longint A3 = 64'sd693598669;
  localparam longint A5 = 64'sd85569306;
  localparam longint A7 = 64'sd5026994;
  localparam longint A9 = 64'sd172273;

  // field of view of one radian in binary-angle units
  localparam logic [13:0] FOV_BA = 14'd10430;
  localparam logic [15:0] HALF_FOV_BA = 16'd5215;

  // datapath widths
  localparam int SCALE_W = 28;
  localparam int ACC_W = 32;
  localparam int DIST_W = 17;
  localparam int POS_W = 19;
  localparam int CELL_W = POS_W - 1 - 12;
  localparam int PROD_W = 33;
  localparam int CORR_W = PROD_W - 14;

  // restoring divider, one instance each in front and back
  localparam int DIV_W = 26;
  localparam int DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WALL_MAP      = 3'd0,
    REG_MAX_DISTANCE  = 3'd1,
    REG_STEP_SIZE     = 3'd2,
    REG_SCREEN_WIDTH  = 3'd3,
    REG_SCREEN_HEIGHT = 3'd4
  } cfg_reg_t;

  localparam logic [63:0] WALL_MAP_RESET = 64'hFF85_8181_9183_81FF;
  localparam logic [15:0] MAX_DISTANCE_RESET = 16'd32768;
  localparam logic [11:0] STEP_SIZE_RESET = 12'd41;
  localparam logic [11:0] SCREEN_WIDTH_RESET = 12'd512;
  localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd512;

  typedef logic signed [15:0] trig_t;

  // register values as the datapath uses them (zero sizes already forced to one)
  typedef struct packed {
    logic [63:0] wall_map;
    logic [15:0] max_distance;
    logic [11:0] step_size;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [14:0]               viewer_x;
    logic [14:0]               viewer_y;
    trig_t                     corr_cos;
    logic signed [SCALE_W-1:0] step_x;
    logic signed [SCALE_W-1:0] step_y;
  } march_job_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_DIVIDE,
    FS_ANGLE,
    FS_COS,
    FS_SIN,
    FS_CORR,
    FS_SCALE_X,
    FS_SCALE_Y,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MARCH,
    BS_CORR,
    BS_HEIGHT,
    BS_DIVIDE,
    BS_EMIT
  } back_state_t;

  // quarter-wave sine for table entry k, Q14, evaluated at elaboration
  function automatic logic [14:0] quarter_sine(int k);
    longint x;
    longint x2;
    longint r;
    x = longint'(k) <<< (TRIG_SHIFT + 16);
    x2 = (x * x) / Q30_ONE;
    r = A7 - (x2 * A9) / Q30_ONE;
    r = A5 - (x2 * r) / Q30_ONE;
    r = A3 - (x2 * r) / Q30_ONE;
    r = A1 - (x2 * r) / Q30_ONE;
    r = (x * r) / Q30_ONE;
    if (r < 0) begin
      r = 0;
    end
    r = (r + 32768) >>> 16;
    if (r > 16384) begin
      r = 16384;
    end
    return 15'(r);
  endfunction

endpackage

// ===== sv/grmc_divider.sv =====
module grmc_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [grmc_pkg::DIV_W-1:0]     dividend,
  input  logic [grmc_pkg::DEN_W-1:0]     divisor,
  output logic                           done,
  output logic [grmc_pkg::DIV_W-1:0]     quotient
);

  logic [grmc_pkg::DIV_W-1:0]     num;
  logic [grmc_pkg::DEN_W-1:0]     den;
  logic [grmc_pkg::DEN_W-1:0]     rem;
  logic [grmc_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [grmc_pkg::DEN_W:0]       trial;
  logic                           fits;

  // one quotient bit a cycle, msb first
  assign trial = {rem, num[grmc_pkg::DIV_W-1]};
  assign fits = trial >= {1'b0, den};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      cnt <= grmc_pkg::DIV_CNT_W'(grmc_pkg::DIV_W - 1);
    end else if (busy) begin
      rem <= fits ? grmc_pkg::DEN_W'(trial - {1'b0, den}) : trial[grmc_pkg::DEN_W-1:0];
      num <= {num[grmc_pkg::DIV_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== sv/grmc_front.sv =====
module grmc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  grmc_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [14:0]          viewer_x,
  input  logic [14:0]          viewer_y,
  input  logic [15:0]          view_angle,
  input  logic [11:0]          column,
  output logic                 job_valid,
  input  logic                 job_ready,
  output grmc_pkg::march_job_t job
);

  grmc_pkg::front_state_t state;
  grmc_pkg::front_state_t state_next;

  logic [14:0]    vx;
  logic [14:0]    vy;
  logic [15:0]    view;
  logic [15:0]    ray;
  logic [15:0]    corr;
  grmc_pkg::trig_t ray_cos;
  grmc_pkg::trig_t ray_sin;
  grmc_pkg::trig_t corr_cos;
  logic signed [grmc_pkg::SCALE_W-1:0] step_x;
  logic signed [grmc_pkg::SCALE_W-1:0] step_y;
  logic signed [grmc_pkg::SCALE_W-1:0] step_s;

  logic                          div_start;
  logic                          div_done;
  logic [grmc_pkg::DIV_W-1:0]    div_quot;
  logic [grmc_pkg::DIV_W-1:0]    col_prod;

  logic [15:0]                   rom_angle;
  logic [15:0]                   rom_phase;
  logic [14:0]                   rom_x;
  logic [grmc_pkg::QTR_IDX_W-1:0] rom_idx;
  grmc_pkg::trig_t               rom_mag;
  grmc_pkg::trig_t               rom_val;
  logic [14:0]                   qtr_rom [grmc_pkg::QTR_ENTRIES];

  for (genvar g = 0; g < grmc_pkg::QTR_ENTRIES; g++) begin : g_qtr
    assign qtr_rom[g] = grmc_pkg::quarter_sine(g);
  end

  // angle offset of the column: column * fov / width
  assign col_prod = grmc_pkg::DIV_W'(column) * grmc_pkg::DIV_W'(grmc_pkg::FOV_BA);

  grmc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (col_prod),
    .divisor  (grmc_pkg::DEN_W'(cfg.screen_width)),
    .done     (div_done),
    .quotient (div_quot)
  );

  // table read: fold the phase onto the quarter wave, sign from the half
  assign rom_phase = rom_angle & grmc_pkg::PHASE_MASK;
  assign rom_x = rom_phase[14] ? 15'(grmc_pkg::QUARTER_TURN - {1'b0, rom_phase[13:0]})
                               : {1'b0, rom_phase[13:0]};
  assign rom_idx = grmc_pkg::QTR_IDX_W'(rom_x >> grmc_pkg::TRIG_SHIFT);
  assign rom_mag = {1'b0, qtr_rom[rom_idx]};

  always_ff @(posedge clk) begin
    rom_val <= rom_phase[15] ? -rom_mag : rom_mag;
  end

  assign step_s = grmc_pkg::SCALE_W'($signed({1'b0, cfg.step_size}));

  always_comb begin
    state_next = state;
    case (state)
      grmc_pkg::FS_IDLE:    if (in_valid) state_next = grmc_pkg::FS_DIVIDE;
      grmc_pkg::FS_DIVIDE:  if (div_done) state_next = grmc_pkg::FS_ANGLE;
      grmc_pkg::FS_ANGLE:   state_next = grmc_pkg::FS_COS;
      grmc_pkg::FS_COS:     state_next = grmc_pkg::FS_SIN;
      grmc_pkg::FS_SIN:     state_next = grmc_pkg::FS_CORR;
      grmc_pkg::FS_CORR:    state_next = grmc_pkg::FS_SCALE_X;
      grmc_pkg::FS_SCALE_X: state_next = grmc_pkg::FS_SCALE_Y;
      grmc_pkg::FS_SCALE_Y: state_next = grmc_pkg::FS_PUSH;
      grmc_pkg::FS_PUSH:    if (job_ready) state_next = grmc_pkg::FS_IDLE;
      default:              state_next = grmc_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_start = 1'b0;
    job_valid = 1'b0;
    rom_angle = ray;
    case (state)
      grmc_pkg::FS_IDLE: begin
        in_ready = 1'b1;
        div_start = in_valid;
      end
      grmc_pkg::FS_ANGLE: rom_angle = ray + grmc_pkg::COS_OFFSET;
      grmc_pkg::FS_COS:   rom_angle = ray;
      grmc_pkg::FS_SIN:   rom_angle = corr + grmc_pkg::COS_OFFSET;
      grmc_pkg::FS_PUSH:  job_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grmc_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      grmc_pkg::FS_IDLE: begin
        if (in_valid) begin
          vx <= viewer_x;
          vy <= viewer_y;
          view <= view_angle;
        end
      end
      grmc_pkg::FS_DIVIDE: begin
        if (div_done) begin
          ray <= view - grmc_pkg::HALF_FOV_BA + div_quot[15:0];
          corr <= div_quot[15:0] - grmc_pkg::HALF_FOV_BA;
        end
      end
      grmc_pkg::FS_COS:     ray_cos <= rom_val;
      grmc_pkg::FS_SIN:     ray_sin <= rom_val;
      grmc_pkg::FS_CORR:    corr_cos <= rom_val;
      grmc_pkg::FS_SCALE_X: step_x <= step_s * grmc_pkg::SCALE_W'(ray_cos);
      grmc_pkg::FS_SCALE_Y: step_y <= step_s * grmc_pkg::SCALE_W'(ray_sin);
      default: ;
    endcase
  end

  assign job.viewer_x = vx;
  assign job.viewer_y = vy;
  assign job.corr_cos = corr_cos;
  assign job.step_x = step_x;
  assign job.step_y = step_y;

endmodule

// ===== sv/grmc_queue.sv =====
module grmc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  grmc_pkg::march_job_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output grmc_pkg::march_job_t pop_data
);

  grmc_pkg::march_job_t            slots [grmc_pkg::QUEUE_DEPTH];
  logic [grmc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [grmc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [grmc_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = count != grmc_pkg::QUEUE_CNT_W'(grmc_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == grmc_pkg::QUEUE_PTR_W'(grmc_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == grmc_pkg::QUEUE_PTR_W'(grmc_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/grmc_back.sv =====
module grmc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  grmc_pkg::cfg_t       cfg,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  grmc_pkg::march_job_t job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [11:0]          slice_top,
  output logic [11:0]          slice_bottom,
  output logic [15:0]          ray_distance
);

  grmc_pkg::back_state_t state;
  grmc_pkg::back_state_t state_next;

  logic [14:0]                          vx;
  logic [14:0]                          vy;
  grmc_pkg::trig_t                      corr_cos;
  logic signed [grmc_pkg::SCALE_W-1:0]  step_x;
  logic signed [grmc_pkg::SCALE_W-1:0]  step_y;
  logic signed [grmc_pkg::ACC_W-1:0]    acc_x;
  logic signed [grmc_pkg::ACC_W-1:0]    acc_y;
  logic [grmc_pkg::DIST_W-1:0]          march_dist;
  logic signed [grmc_pkg::PROD_W-1:0]   prod;

  logic        res_hit;
  logic [11:0] res_top;
  logic [11:0] res_bottom;
  logic [15:0] res_dist;

  logic signed [grmc_pkg::POS_W-1:0]  pos_x;
  logic signed [grmc_pkg::POS_W-1:0]  pos_y;
  logic [grmc_pkg::CELL_W-1:0]        row;
  logic [grmc_pkg::CELL_W-1:0]        col;
  logic [grmc_pkg::MAP_IDX_W-1:0]     cell_idx;
  logic                               wall;
  logic                               in_range;

  logic signed [grmc_pkg::CORR_W-1:0] corr_dist;
  logic                               corr_pos;

  logic                          div_start;
  logic                          div_done;
  logic [grmc_pkg::DIV_W-1:0]    div_quot;
  logic [grmc_pkg::DIV_W-2:0]    half;
  logic [10:0]                   mid;
  logic [grmc_pkg::DIV_W-1:0]    bot_sum;
  logic [11:0]                   last_row;
  logic [11:0]                   top_calc;
  logic [11:0]                   bot_calc;
  logic                          load_out;

  // position at the current distance, floor of the Q14 product
  assign pos_x = grmc_pkg::POS_W'($signed({1'b0, vx})) + grmc_pkg::POS_W'(acc_x >>> 14);
  assign pos_y = grmc_pkg::POS_W'($signed({1'b0, vy})) + grmc_pkg::POS_W'(acc_y >>> 14);
  assign row = pos_x[grmc_pkg::POS_W-2:12];
  assign col = pos_y[grmc_pkg::POS_W-2:12];
  assign cell_idx = grmc_pkg::MAP_IDX_W'(row[grmc_pkg::MAP_ROW_W-1:0])
                  * grmc_pkg::MAP_IDX_W'(grmc_pkg::MAP_SIDE)
                  + grmc_pkg::MAP_IDX_W'(col[grmc_pkg::MAP_ROW_W-1:0]);

  // outside the map counts as wall
  assign wall = pos_x[grmc_pkg::POS_W-1] || pos_y[grmc_pkg::POS_W-1]
             || (row >= grmc_pkg::CELL_W'(grmc_pkg::MAP_SIDE))
             || (col >= grmc_pkg::CELL_W'(grmc_pkg::MAP_SIDE))
             || cfg.wall_map[cell_idx];
  assign in_range = march_dist < {1'b0, cfg.max_distance};

  assign corr_dist = grmc_pkg::CORR_W'(prod >>> 14);
  assign corr_pos = !corr_dist[grmc_pkg::CORR_W-1] && (corr_dist != '0);

  grmc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (grmc_pkg::DIV_W'({cfg.screen_width, 12'd0})),
    .divisor  (grmc_pkg::DEN_W'(corr_dist)),
    .done     (div_done),
    .quotient (div_quot)
  );

  // centre the slice and clip it to the screen
  assign half = div_quot[grmc_pkg::DIV_W-1:1];
  assign mid = cfg.screen_height[11:1];
  assign last_row = cfg.screen_height - 1'b1;
  assign bot_sum = grmc_pkg::DIV_W'(mid) + grmc_pkg::DIV_W'(half);
  assign top_calc = (half >= (grmc_pkg::DIV_W-1)'(mid)) ? '0 : 12'(mid - half[10:0]);
  assign bot_calc = (bot_sum > grmc_pkg::DIV_W'(last_row)) ? last_row : bot_sum[11:0];

  always_comb begin
    state_next = state;
    case (state)
      grmc_pkg::BS_IDLE:   if (job_valid) state_next = grmc_pkg::BS_MARCH;
      grmc_pkg::BS_MARCH: begin
        if (!in_range) begin
          state_next = grmc_pkg::BS_EMIT;
        end else if (wall) begin
          state_next = grmc_pkg::BS_CORR;
        end
      end
      grmc_pkg::BS_CORR:   state_next = grmc_pkg::BS_HEIGHT;
      grmc_pkg::BS_HEIGHT: state_next = corr_pos ? grmc_pkg::BS_DIVIDE : grmc_pkg::BS_EMIT;
      grmc_pkg::BS_DIVIDE: if (div_done) state_next = grmc_pkg::BS_EMIT;
      grmc_pkg::BS_EMIT:   if (!out_valid || out_ready) state_next = grmc_pkg::BS_IDLE;
      default:             state_next = grmc_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    div_start = 1'b0;
    load_out = 1'b0;
    case (state)
      grmc_pkg::BS_IDLE:   job_ready = 1'b1;
      grmc_pkg::BS_HEIGHT: div_start = corr_pos;
      grmc_pkg::BS_EMIT:   load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grmc_pkg::BS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      grmc_pkg::BS_IDLE: begin
        if (job_valid) begin
          vx <= job.viewer_x;
          vy <= job.viewer_y;
          corr_cos <= job.corr_cos;
          step_x <= job.step_x;
          step_y <= job.step_y;
          acc_x <= '0;
          acc_y <= '0;
          march_dist <= '0;
        end
      end
      grmc_pkg::BS_MARCH: begin
        if (!in_range) begin
          res_hit <= 1'b0;
          res_top <= '0;
          res_bottom <= '0;
          res_dist <= '0;
        end else if (wall) begin
          res_hit <= 1'b1;
          res_dist <= march_dist[15:0];
        end else begin
          march_dist <= march_dist + grmc_pkg::DIST_W'(cfg.step_size);
          acc_x <= acc_x + grmc_pkg::ACC_W'(step_x);
          acc_y <= acc_y + grmc_pkg::ACC_W'(step_y);
        end
      end
      grmc_pkg::BS_CORR: begin
        prod <= grmc_pkg::PROD_W'($signed({1'b0, march_dist[15:0]}))
              * grmc_pkg::PROD_W'(corr_cos);
      end
      grmc_pkg::BS_HEIGHT: begin
        // wall at or behind the viewer plane fills the column
        if (!corr_pos) begin
          res_top <= '0;
          res_bottom <= last_row;
        end
      end
      grmc_pkg::BS_DIVIDE: begin
        if (div_done) begin
          res_top <= top_calc;
          res_bottom <= bot_calc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit <= res_hit;
      slice_top <= res_top;
      slice_bottom <= res_bottom;
      ray_distance <= res_dist;
    end
  end

endmodule

// ===== sv/grid_ray_march_column.sv =====
// channel   direction  transfer when          payload
// in        input      in_valid & in_ready    viewer_x, viewer_y, view_angle, column
// out       output     out_valid & out_ready  hit, slice_top, slice_bottom, ray_distance
// cfg       input      cfg_write              cfg_index, cfg_data
//
// front: per column, a divider for the ray angle, three table reads and two step-scale
// multiplies; back: one march step per cycle up to the wall or max_distance / step_size
// steps, then the distance correction and the height divider.
// the back march loop sets the sustained rate; a two-entry queue parts front and back.
// reset loads the register defaults and empties queue and output register; no sweep.
// a waiting output result stalls the back, and new transfers in once the queue is full.
module grid_ray_march_column (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [grmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [grmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [14:0]                        viewer_x,
  input  logic [14:0]                        viewer_y,
  input  logic [15:0]                        view_angle,
  input  logic [11:0]                        column,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               hit,
  output logic [11:0]                        slice_top,
  output logic [11:0]                        slice_bottom,
  output logic [15:0]                        ray_distance
);

  logic [63:0] wall_map;
  logic [15:0] max_distance;
  logic [11:0] step_size;
  logic [11:0] screen_width;
  logic [11:0] screen_height;

  grmc_pkg::cfg_t       cfg;
  logic                 push_valid;
  logic                 push_ready;
  grmc_pkg::march_job_t push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  grmc_pkg::march_job_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map <= grmc_pkg::WALL_MAP_RESET;
      max_distance <= grmc_pkg::MAX_DISTANCE_RESET;
      step_size <= grmc_pkg::STEP_SIZE_RESET;
      screen_width <= grmc_pkg::SCREEN_WIDTH_RESET;
      screen_height <= grmc_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (grmc_pkg::cfg_reg_t'(cfg_index))
        grmc_pkg::REG_WALL_MAP:      wall_map <= cfg_data;
        grmc_pkg::REG_MAX_DISTANCE:  max_distance <= cfg_data[15:0];
        grmc_pkg::REG_STEP_SIZE:     step_size <= cfg_data[11:0];
        grmc_pkg::REG_SCREEN_WIDTH:  screen_width <= cfg_data[11:0];
        grmc_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // zero sizes behave as one
  assign cfg.wall_map = wall_map;
  assign cfg.max_distance = max_distance;
  assign cfg.step_size = (step_size == '0) ? 12'd1 : step_size;
  assign cfg.screen_width = (screen_width == '0) ? 12'd1 : screen_width;
  assign cfg.screen_height = (screen_height == '0) ? 12'd1 : screen_height;

  grmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .viewer_x   (viewer_x),
    .viewer_y   (viewer_y),
    .view_angle (view_angle),
    .column     (column),
    .job_valid  (push_valid),
    .job_ready  (push_ready),
    .job        (push_data)
  );

  grmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  grmc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (pop_valid),
    .job_ready    (pop_ready),
    .job          (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .slice_top    (slice_top),
    .slice_bottom (slice_bottom),
    .ray_distance (ray_distance)
  );

endmodule

// ===== sv/grmc_checker.sv =====
module grmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [11:0] slice_top,
  input logic [11:0] slice_bottom,
  input logic [15:0] ray_distance
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(slice_top)
      && $stable(slice_bottom) && $stable(ray_distance))
    else $error("result changed while stalled");

  // a miss carries no slice and no distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> slice_top == 12'd0 && slice_bottom == 12'd0
      && ray_distance == 16'd0)
    else $error("miss with non-zero fields");

  // the slice is never inverted
  a_slice_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> slice_top <= slice_bottom)
    else $error("slice top below bottom");

endmodule

bind grid_ray_march_column grmc_checker u_grmc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .hit          (hit),
  .slice_top    (slice_top),
  .slice_bottom (slice_bottom),
  .ray_distance (ray_distance)
);
